// ===== src/cufu_pkg.sv =====
// shared types for the cholesky upper factor unit
package cufu_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LDIV,
        ST_FSTART,
        ST_FRD,
        ST_FMUL,
        ST_FACC,
        ST_FRDA,
        ST_FDIFF,
        ST_FEVAL,
        ST_SQ,
        ST_PIVWR,
        ST_DIV,
        ST_INV,
        ST_OFFMUL,
        ST_OFFWR,
        ST_ORD
    } state_t;

    typedef enum logic {
        USRC_ROOT,
        USRC_OFF
    } u_src_t;

    typedef enum logic {
        MSEL_DOT,
        MSEL_OFF
    } mul_sel_t;

    typedef struct packed {
        logic     take_elem;
        logic     store_we;
        logic     store_re;
        logic     u_re;
        logic     u_we;
        u_src_t   u_src;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_clr;
        logic     acc_add;
        logic     diff_load;
        logic     e_load;
        logic     sq_init;
        logic     sq_step;
        logic     div_init;
        logic     div_step;
        logic     inv_load;
        logic     out_load;
        logic     out_zero;
        logic     out_end;
        logic     out_flag;
    } cmd_t;

    typedef struct packed {
        logic diff_pos;
        logic out_busy;
    } status_t;

endpackage

// ===== src/cholesky_upper_factor_unit.sv =====
// Upper-triangular Cholesky factor of a streamed symmetric matrix, signed fixed point.
// Elements arrive one beat at a time in column-major order; each element is placed at
// its column, found by repeated subtraction of n. After the beat marked last the factor
// is computed with one shared multiplier for the multiply-adds of the column dot products,
// and per pivot a bit-serial square root of (31+FRAC_BITS+1)/2 root bits and a bit-serial
// reciprocal of 2*FRAC_BITS+1 quotient bits (24 and 33 at FRAC_BITS of 16); the n(n+1)/2
// results then leave one beat at a time, held while the output is stalled. Input stalls
// from the accepted element until its work is done; a finished result waits in the output
// register while the next matrix loads. The element and factor stores come out of reset
// unwritten and need no clearing pass.
module cholesky_upper_factor_unit #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] element,
    input  logic               is_last,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] factor_value,
    output logic [2:0]         row_index,
    output logic [2:0]         col_index,
    output logic               end_of_factor,
    output logic               not_positive_definite,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;

    cufu_pkg::cmd_t    cmd;
    cufu_pkg::status_t status;
    logic [AW-1:0]     store_addr;
    logic [AW-1:0]     ua_addr;
    logic [AW-1:0]     ub_addr;
    logic [IW-1:0]     out_row;
    logic [IW-1:0]     out_col;

    cufu_ctrl #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .is_last    (is_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .status     (status),
        .cmd        (cmd),
        .store_addr (store_addr),
        .ua_addr    (ua_addr),
        .ub_addr    (ub_addr),
        .out_row    (out_row),
        .out_col    (out_col)
    );

    cufu_dpath #(
        .MAX_ORDER (MAX_ORDER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .element               (element),
        .store_addr            (store_addr),
        .ua_addr               (ua_addr),
        .ub_addr               (ub_addr),
        .out_row               (out_row),
        .out_col               (out_col),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .factor_value          (factor_value),
        .row_index             (row_index),
        .col_index             (col_index),
        .end_of_factor         (end_of_factor),
        .not_positive_definite (not_positive_definite)
    );

endmodule

// ===== src/cufu_ctrl.sv =====
// sequencer for loading, factorization and readout
module cufu_ctrl #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   is_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [3:0]             cfg_data,
    input  cufu_pkg::status_t      status,
    output cufu_pkg::cmd_t         cmd,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1)-1:0] store_addr,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1)-1:0] ua_addr,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1)-1:0] ub_addr,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0]             out_row,
    output logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0]             out_col
);

    localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int AW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1;
    localparam int NW    = $clog2(MAX_ORDER + 1);
    localparam int PW    = NW + 1;
    localparam int LW    = $clog2(MAX_ORDER * MAX_ORDER + 1);
    localparam int SQ    = (31 + FRAC_BITS + 1) / 2;
    localparam int QW    = 2 * FRAC_BITS + 1;
    localparam int ITMAX = (SQ > QW) ? SQ : QW;
    localparam int CW    = $clog2(ITMAX);

    cufu_pkg::state_t state_reg, state_next;
    logic [3:0]    cfg_reg, cfg_next;
    logic [LW-1:0] load_count_reg, load_count_next;
    logic [LW-1:0] rem_reg, rem_next;
    logic [IW-1:0] c_reg, c_next;
    logic          last_reg, last_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] oi_reg, oi_next;
    logic [IW-1:0] oj_reg, oj_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          err_reg, err_next;
    logic [IW-1:0] err_row_reg, err_row_next;
    // marks that the factor word for the current readout position is in the read register
    logic          rd_pend_reg, rd_pend_next;

    logic [NW-1:0] n;
    logic [LW-1:0] nn;

    function automatic logic [AW-1:0] mk_addr(input logic [IW-1:0] a, input logic [IW-1:0] b);
        mk_addr = AW'(AW'(a) * AW'(MAX_ORDER)) + AW'(b);
    endfunction

    always_comb
    begin
        if (cfg_reg == 4'd0)
        begin
            n = NW'(1);
        end
        else if (32'(cfg_reg) > MAX_ORDER)
        begin
            n = NW'(MAX_ORDER);
        end
        else
        begin
            n = NW'(cfg_reg);
        end
        nn = LW'(n) * LW'(n);
    end

    assign cfg_ready   = 1'b1;
    assign in_stall    = (state_reg != cufu_pkg::ST_IDLE);
    assign out_row     = oi_reg;
    assign out_col     = oj_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cufu_pkg::ST_IDLE;
            cfg_reg        <= 4'd8;
            load_count_reg <= '0;
            rem_reg        <= '0;
            c_reg          <= '0;
            last_reg       <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            oi_reg         <= '0;
            oj_reg         <= '0;
            cnt_reg        <= '0;
            err_reg        <= 1'b0;
            err_row_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            load_count_reg <= load_count_next;
            rem_reg        <= rem_next;
            c_reg          <= c_next;
            last_reg       <= last_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            oi_reg         <= oi_next;
            oj_reg         <= oj_next;
            cnt_reg        <= cnt_next;
            err_reg        <= err_next;
            err_row_reg    <= err_row_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        load_count_next = load_count_reg;
        rem_next        = rem_reg;
        c_next          = c_reg;
        last_next       = last_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        oi_next         = oi_reg;
        oj_next         = oj_reg;
        cnt_next        = cnt_reg;
        err_next        = err_reg;
        err_row_next    = err_row_reg;
        cmd             = '0;
        cmd.u_src       = cufu_pkg::USRC_ROOT;
        cmd.mul_sel     = cufu_pkg::MSEL_DOT;
        cmd.out_flag    = err_reg;
        store_addr      = mk_addr(j_reg, i_reg);
        ua_addr         = mk_addr(k_reg, i_reg);
        ub_addr         = mk_addr(i_reg, j_reg);

        if (cfg_valid)
        begin
            cfg_next = cfg_data;
        end

        case (state_reg)
            cufu_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_elem = 1'b1;
                    last_next     = is_last;
                    if (load_count_reg < nn)
                    begin
                        rem_next   = load_count_reg;
                        c_next     = '0;
                        state_next = cufu_pkg::ST_LDIV;
                    end
                    else if (is_last)
                    begin
                        err_next   = 1'b0;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = cufu_pkg::ST_FSTART;
                    end
                end
            end
            cufu_pkg::ST_LDIV:
            begin
                store_addr = mk_addr(c_reg, rem_reg[IW-1:0]);
                // position from the running count, one subtraction of n a cycle
                if (rem_reg >= LW'(n))
                begin
                    rem_next = rem_reg - LW'(n);
                    c_next   = c_reg + IW'(1);
                end
                else
                begin
                    cmd.store_we    = 1'b1;
                    load_count_next = load_count_reg + LW'(1);
                    if (last_reg)
                    begin
                        err_next   = 1'b0;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = cufu_pkg::ST_FSTART;
                    end
                    else
                    begin
                        state_next = cufu_pkg::ST_IDLE;
                    end
                end
            end
            cufu_pkg::ST_FSTART:
            begin
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                state_next  = (i_reg != '0) ? cufu_pkg::ST_FRD : cufu_pkg::ST_FRDA;
            end
            cufu_pkg::ST_FRD:
            begin
                ua_addr    = mk_addr(k_reg, i_reg);
                ub_addr    = mk_addr(k_reg, j_reg);
                cmd.u_re   = 1'b1;
                state_next = cufu_pkg::ST_FMUL;
            end
            cufu_pkg::ST_FMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cufu_pkg::MSEL_DOT;
                state_next  = cufu_pkg::ST_FACC;
            end
            cufu_pkg::ST_FACC:
            begin
                cmd.acc_add = 1'b1;
                k_next      = k_reg + IW'(1);
                if (((IW + 1)'(k_reg) + (IW + 1)'(1)) < (IW + 1)'(i_reg))
                begin
                    state_next = cufu_pkg::ST_FRD;
                end
                else
                begin
                    state_next = cufu_pkg::ST_FRDA;
                end
            end
            cufu_pkg::ST_FRDA:
            begin
                store_addr   = mk_addr(j_reg, i_reg);
                cmd.store_re = 1'b1;
                state_next   = cufu_pkg::ST_FDIFF;
            end
            cufu_pkg::ST_FDIFF:
            begin
                cmd.diff_load = 1'b1;
                state_next    = cufu_pkg::ST_FEVAL;
            end
            cufu_pkg::ST_FEVAL:
            begin
                if (i_reg == j_reg)
                begin
                    if (!status.diff_pos)
                    begin
                        err_next     = 1'b1;
                        err_row_next = i_reg;
                        oi_next      = '0;
                        oj_next      = '0;
                        state_next   = cufu_pkg::ST_ORD;
                    end
                    else
                    begin
                        cmd.sq_init = 1'b1;
                        cnt_next    = CW'(SQ - 1);
                        state_next  = cufu_pkg::ST_SQ;
                    end
                end
                else
                begin
                    cmd.e_load = 1'b1;
                    state_next = cufu_pkg::ST_OFFMUL;
                end
            end
            cufu_pkg::ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = cufu_pkg::ST_PIVWR;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            cufu_pkg::ST_PIVWR:
            begin
                ub_addr      = mk_addr(i_reg, i_reg);
                cmd.u_we     = 1'b1;
                cmd.u_src    = cufu_pkg::USRC_ROOT;
                cmd.div_init = 1'b1;
                cnt_next     = CW'(QW - 1);
                state_next   = cufu_pkg::ST_DIV;
            end
            cufu_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = cufu_pkg::ST_INV;
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            cufu_pkg::ST_INV:
            begin
                cmd.inv_load = 1'b1;
                if ((PW'(i_reg) + PW'(1)) < PW'(n))
                begin
                    j_next     = i_reg + IW'(1);
                    state_next = cufu_pkg::ST_FSTART;
                end
                else
                begin
                    oi_next    = '0;
                    oj_next    = '0;
                    state_next = cufu_pkg::ST_ORD;
                end
            end
            cufu_pkg::ST_OFFMUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = cufu_pkg::MSEL_OFF;
                state_next  = cufu_pkg::ST_OFFWR;
            end
            cufu_pkg::ST_OFFWR:
            begin
                ub_addr    = mk_addr(i_reg, j_reg);
                cmd.u_we   = 1'b1;
                cmd.u_src  = cufu_pkg::USRC_OFF;
                state_next = cufu_pkg::ST_FSTART;
                if ((PW'(j_reg) + PW'(1)) < PW'(n))
                begin
                    j_next = j_reg + IW'(1);
                end
                else
                begin
                    // row done, next pivot sits on the diagonal
                    i_next = i_reg + IW'(1);
                    j_next = i_reg + IW'(1);
                end
            end
            cufu_pkg::ST_ORD:
            begin
                ua_addr = mk_addr(oi_reg, oj_reg);
                if (!status.out_busy)
                begin
                    cmd.u_re = 1'b1;
                end
            end
            default:
            begin
                state_next = cufu_pkg::ST_IDLE;
            end
        endcase

        // readout: a read in ORD is followed by the output load in the cycle after it
        if (state_reg == cufu_pkg::ST_ORD && !status.out_busy && rd_pend_reg)
        begin
            cmd.u_re     = 1'b0;
            cmd.out_load = 1'b1;
            cmd.out_zero = err_reg && (oi_reg >= err_row_reg);
            cmd.out_end  = ((PW'(oj_reg) + PW'(1)) == PW'(n)) && (oi_reg == oj_reg);
            if (oi_reg < oj_reg)
            begin
                oi_next = oi_reg + IW'(1);
            end
            else if ((PW'(oj_reg) + PW'(1)) < PW'(n))
            begin
                oi_next = '0;
                oj_next = oj_reg + IW'(1);
            end
            else
            begin
                load_count_next = '0;
                state_next      = cufu_pkg::ST_IDLE;
            end
        end
    end

    always_comb
    begin
        rd_pend_next = rd_pend_reg;
        if (state_reg == cufu_pkg::ST_ORD && !status.out_busy)
        begin
            rd_pend_next = !rd_pend_reg;
        end
        else if (state_reg != cufu_pkg::ST_ORD)
        begin
            rd_pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_pend_next;
        end
    end

endmodule

// ===== src/cufu_dpath.sv =====
// storage, multiplier, accumulator, root and reciprocal steps, output register
module cufu_dpath #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cufu_pkg::cmd_t      cmd,
    output cufu_pkg::status_t   status,
    input  logic signed [31:0]  element,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1)-1:0] store_addr,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1)-1:0] ua_addr,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER * MAX_ORDER) : 1)-1:0] ub_addr,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0]             out_row,
    input  logic [((MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1)-1:0]             out_col,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  factor_value,
    output logic [2:0]          row_index,
    output logic [2:0]          col_index,
    output logic                end_of_factor,
    output logic                not_positive_definite
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int ACCW  = 70 - FRAC_BITS;
    localparam int DW    = ACCW + 1;
    localparam int SQ    = (31 + FRAC_BITS + 1) / 2;
    localparam int QW    = 2 * FRAC_BITS + 1;

    localparam logic signed [DW-1:0] D_MAX = DW'(64'sh7FFFFFFF);
    localparam logic signed [DW-1:0] D_MIN = ~D_MAX;
    localparam logic signed [64:0]   P_MAX = 65'sh7FFFFFFF;
    localparam logic signed [64:0]   P_MIN = ~P_MAX;

    logic signed [31:0]   store_mem [DEPTH];
    logic signed [31:0]   u_mem [DEPTH];

    logic signed [31:0]   elem_reg;
    logic signed [31:0]   store_q;
    logic signed [31:0]   ua_q;
    logic signed [31:0]   ub_q;
    logic signed [64:0]   prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [DW-1:0] diff_reg;
    logic signed [31:0]   e_reg;
    logic [2*SQ-1:0]      x_reg;
    logic [SQ+1:0]        sq_rem_reg;
    logic [SQ-1:0]        root_reg;
    logic [31:0]          dv_rem_reg;
    logic                 dv_first_reg;
    logic [QW-1:0]        q_reg;
    logic [30:0]          inv_reg;

    logic signed [31:0]   fv_reg;
    logic [2:0]           row_reg;
    logic [2:0]           col_reg;
    logic                 end_reg;
    logic                 flag_reg;
    logic                 out_valid_reg;

    logic signed [31:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [64:0]   shifted;
    logic signed [31:0]   off_val;
    logic signed [31:0]   u_wdata;
    logic signed [DW-1:0] diff_calc;
    logic [30:0]          d31;
    logic [SQ+1:0]        sq_rem2;
    logic [SQ+1:0]        sq_trial;
    logic [31:0]          dv_rem2;
    logic [31:0]          piv32;
    logic [63:0]          q_ext;

    always_comb
    begin
        mul_a   = (cmd.mul_sel == cufu_pkg::MSEL_OFF) ? e_reg : ua_q;
        mul_b   = (cmd.mul_sel == cufu_pkg::MSEL_OFF) ? $signed({2'b00, inv_reg})
                                                      : $signed({ub_q[31], ub_q});
        // arithmetic shift floors toward minus infinity
        shifted = prod_reg >>> FRAC_BITS;
        if (shifted > P_MAX)
        begin
            off_val = 32'sh7FFFFFFF;
        end
        else if (shifted < P_MIN)
        begin
            off_val = 32'sh80000000;
        end
        else
        begin
            off_val = shifted[31:0];
        end
        u_wdata   = (cmd.u_src == cufu_pkg::USRC_OFF) ? off_val : $signed(32'(root_reg));
        diff_calc = DW'(store_q) - DW'(acc_reg);
        d31       = (diff_reg > D_MAX) ? 31'h7FFFFFFF : diff_reg[30:0];
        sq_rem2   = {sq_rem_reg[SQ-1:0], x_reg[2*SQ-1 -: 2]};
        sq_trial  = {root_reg, 2'b01};
        piv32     = 32'(root_reg);
        dv_rem2   = {dv_rem_reg[30:0], dv_first_reg};
        q_ext     = 64'(q_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_we)
        begin
            store_mem[store_addr] <= elem_reg;
        end
        if (cmd.store_re)
        begin
            store_q <= store_mem[store_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.u_we)
        begin
            u_mem[ub_addr] <= u_wdata;
        end
        if (cmd.u_re)
        begin
            ua_q <= u_mem[ua_addr];
            ub_q <= u_mem[ub_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_elem)
        begin
            elem_reg <= element;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + $signed(shifted[ACCW-1:0]);
        end
        if (cmd.diff_load)
        begin
            diff_reg <= diff_calc;
        end
        if (cmd.e_load)
        begin
            if (diff_reg > D_MAX)
            begin
                e_reg <= 32'sh7FFFFFFF;
            end
            else if (diff_reg < D_MIN)
            begin
                e_reg <= 32'sh80000000;
            end
            else
            begin
                e_reg <= diff_reg[31:0];
            end
        end
        // square root, two radicand bits a step
        if (cmd.sq_init)
        begin
            x_reg      <= (2*SQ)'({d31, {FRAC_BITS{1'b0}}});
            sq_rem_reg <= '0;
            root_reg   <= '0;
        end
        else if (cmd.sq_step)
        begin
            x_reg <= x_reg << 2;
            if (sq_rem2 >= sq_trial)
            begin
                sq_rem_reg <= sq_rem2 - sq_trial;
                root_reg   <= {root_reg[SQ-2:0], 1'b1};
            end
            else
            begin
                sq_rem_reg <= sq_rem2;
                root_reg   <= {root_reg[SQ-2:0], 1'b0};
            end
        end
        // reciprocal of the pivot, one quotient bit a step
        if (cmd.div_init)
        begin
            dv_rem_reg   <= '0;
            dv_first_reg <= 1'b1;
            q_reg        <= '0;
        end
        else if (cmd.div_step)
        begin
            dv_first_reg <= 1'b0;
            if (dv_rem2 >= piv32)
            begin
                dv_rem_reg <= dv_rem2 - piv32;
                q_reg      <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                dv_rem_reg <= dv_rem2;
                q_reg      <= {q_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.inv_load)
        begin
            inv_reg <= (q_ext > 64'h7FFFFFFF) ? 31'h7FFFFFFF : q_ext[30:0];
        end
        if (cmd.out_load)
        begin
            fv_reg   <= cmd.out_zero ? 32'sd0 : ua_q;
            row_reg  <= 3'(out_row);
            col_reg  <= 3'(out_col);
            end_reg  <= cmd.out_end;
            flag_reg <= cmd.out_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.diff_pos       = (diff_reg > DW'(0));
    assign status.out_busy       = out_valid_reg;
    assign out_valid             = out_valid_reg;
    assign factor_value          = fv_reg;
    assign row_index             = row_reg;
    assign col_index             = col_reg;
    assign end_of_factor         = end_reg;
    assign not_positive_definite = flag_reg;

endmodule

// ===== src/cufu_checker.sv =====
// port-level checks for the cholesky upper factor unit, bound to the top level
module cufu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] factor_value,
    input logic [2:0]         row_index,
    input logic [2:0]         col_index,
    input logic               end_of_factor,
    input logic               not_positive_definite
);

    // a held beat keeps its value and row index
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(factor_value) && $stable(row_index))
        else $error("stalled result beat changed");

    a_upper: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> row_index <= col_index)
        else $error("result below the diagonal");

    a_end_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_factor |-> row_index == col_index)
        else $error("end mark off the diagonal");

    // pivots of a good factor are at least one lsb
    a_pivot_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !not_positive_definite && row_index == col_index |-> factor_value > 0)
        else $error("non-positive pivot without error flag");

endmodule

bind cholesky_upper_factor_unit cufu_checker u_cufu_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .factor_value          (factor_value),
    .row_index             (row_index),
    .col_index             (col_index),
    .end_of_factor         (end_of_factor),
    .not_positive_definite (not_positive_definite)
);

// ===== dv/cholesky_upper_factor_unit_tb.sv =====
// testbench for the cholesky upper factor unit: directed table then random matrices
module cholesky_upper_factor_unit_tb;

    localparam int ORDER_MAX  = 8;
    localparam int FRAC       = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int SETTLE     = 40;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         row;
        logic [2:0]         col;
        logic               last_entry;
        logic               bad_pivot;
    } factor_entry_t;

    typedef struct {
        int                 size_wr;   // -1: leave the size alone
        logic signed [31:0] el;
        bit                 last;
        bit                 typed;
        logic signed [31:0] want_value;
        bit                 want_flag;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] element;
    logic               is_last;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] factor_value;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic               end_of_factor;
    logic               not_positive_definite;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [3:0]         cfg_data;

    cholesky_upper_factor_unit #(
        .MAX_ORDER (ORDER_MAX),
        .FRAC_BITS (FRAC)
    ) dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .element               (element),
        .is_last               (is_last),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .factor_value          (factor_value),
        .row_index             (row_index),
        .col_index             (col_index),
        .end_of_factor         (end_of_factor),
        .not_positive_definite (not_positive_definite),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_data              (cfg_data)
    );

    // predictor state
    longint        elem_store [ORDER_MAX*ORDER_MAX];
    bit            elem_written [ORDER_MAX*ORDER_MAX];
    int unsigned   loaded;
    logic [3:0]    size_reg;
    factor_entry_t pending_entries [$];

    int errors;
    int beats_sent;
    int entries_seen;
    int factors_done;
    int pivot_fails;
    int idle_cycles;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int unsigned order_of(logic [3:0] s);
        if (s == 0)
            return 1;
        if (s > ORDER_MAX)
            return ORDER_MAX;
        return s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned int_root(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // dot product of columns a and b of the factor over rows 0..len-1
    function automatic longint column_dot(longint u [ORDER_MAX][ORDER_MAX], int a, int b, int len);
        longint acc;
        acc = 0;
        for (int k = 0; k < len; k++)
            acc += (u[k][a] * u[k][b]) >>> FRAC;
        return acc;
    endfunction

    // take one element; on the last mark, queue the whole factor
    function automatic void factor_beat(logic signed [31:0] el, bit last);
        int unsigned n;
        longint      u [ORDER_MAX][ORDER_MAX];
        longint      d;
        longint      piv;
        longint      inv;
        longint      e;
        bit          fail;
        factor_entry_t fe;
        n = order_of(size_reg);
        if (loaded < n*n)
        begin
            elem_store[(loaded / n)*ORDER_MAX + loaded % n] = el;
            elem_written[(loaded / n)*ORDER_MAX + loaded % n] = 1'b1;
            loaded++;
        end
        if (!last)
            return;
        for (int i = 0; i < ORDER_MAX; i++)
            for (int j = 0; j < ORDER_MAX; j++)
                u[i][j] = 0;
        fail = 1'b0;
        for (int i = 0; i < n && !fail; i++)
        begin
            d = elem_store[i*ORDER_MAX + i] - column_dot(u, i, i, i);
            if (d <= 0)
                fail = 1'b1;
            else
            begin
                if (d > 64'sd2147483647)
                    d = 64'sd2147483647;
                piv = longint'(int_root(longint'(d) << FRAC));
                u[i][i] = piv;
                inv = longint'((64'd1 << (2*FRAC)) / piv);
                if (inv > 64'sd2147483647)
                    inv = 64'sd2147483647;
                for (int j = i + 1; j < n; j++)
                begin
                    e = clip32(elem_store[j*ORDER_MAX + i] - column_dot(u, j, i, i));
                    u[i][j] = clip32((e * inv) >>> FRAC);
                end
            end
        end
        for (int j = 0; j < n; j++)
            for (int i = 0; i <= j; i++)
            begin
                fe.value      = u[i][j][31:0];
                fe.row        = i[2:0];
                fe.col        = j[2:0];
                fe.last_entry = (j == n - 1) && (i == j);
                fe.bad_pivot  = fail;
                pending_entries.push_back(fe);
            end
        factors_done++;
        if (fail)
            pivot_fails++;
        loaded = 0;
    endfunction

    // would a last mark on the element about to go to (r,c) read only written entries
    function automatic bit upper_covered(int unsigned n);
        int unsigned c;
        int unsigned r;
        c = loaded / n;
        r = loaded % n;
        for (int j = 0; j < n; j++)
            for (int i = 0; i <= j; i++)
                if (!elem_written[j*ORDER_MAX + i] && !(i == r && j == c && loaded < n*n))
                    return 1'b0;
        return 1'b1;
    endfunction

    task automatic send_element(logic signed [31:0] el, bit last);
        @(negedge clk);
        in_valid = 1'b1;
        element  = el;
        is_last  = last;
        do
            @(posedge clk);
        while (in_stall);
        factor_beat(el, last);
        beats_sent++;
        // bursts with random gaps
        if ($urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 6))
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_entries.size() != 0)
            @(negedge clk);
        // element placement may still be running
        repeat (SETTLE)
            @(negedge clk);
    endtask

    task automatic write_size(logic [3:0] s);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = s;
        do
            @(posedge clk);
        while (!cfg_ready);
        size_reg = s;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver stalls on its own pattern, in one of four randomly chosen modes
    int unsigned stall_mode;
    int unsigned stall_tick;
    always @(negedge clk)
    begin
        stall_tick++;
        if (stall_tick % 64 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 1) == 0);
            2: out_stall = (stall_tick % 3 == 0);
            default: out_stall = ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        factor_entry_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            entries_seen++;
            if (pending_entries.size() == 0)
            begin
                $display("%0t: unexpected factor beat value %h row %0d col %0d", $time,
                         factor_value, row_index, col_index);
                errors++;
            end
            else
            begin
                want = pending_entries.pop_front();
                if (factor_value !== want.value)
                begin
                    $display("%0t: factor_value expected %h actual %h", $time,
                             want.value, factor_value);
                    errors++;
                end
                if (row_index !== want.row)
                begin
                    $display("%0t: row_index expected %0d actual %0d", $time,
                             want.row, row_index);
                    errors++;
                end
                if (col_index !== want.col)
                begin
                    $display("%0t: col_index expected %0d actual %0d", $time,
                             want.col, col_index);
                    errors++;
                end
                if (end_of_factor !== want.last_entry)
                begin
                    $display("%0t: end_of_factor expected %b actual %b", $time,
                             want.last_entry, end_of_factor);
                    errors++;
                end
                if (not_positive_definite !== want.bad_pivot)
                begin
                    $display("%0t: not_positive_definite expected %b actual %b", $time,
                             want.bad_pivot, not_positive_definite);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    stim_row_t directed [] = '{
        '{1,  32'h0001_0000, 1, 1, 32'h0001_0000, 0},  // 1.0 gives 1.0
        '{-1, 32'h0000_0000, 1, 1, 32'h0000_0000, 1},  // zero pivot
        '{-1, 32'h8000_0000, 1, 1, 32'h0000_0000, 1},  // most negative
        '{-1, 32'h0004_0000, 1, 1, 32'h0002_0000, 0},  // 4.0 gives 2.0
        '{-1, 32'h7fff_ffff, 1, 0, 0, 0},
        '{-1, 32'h0000_0001, 1, 1, 32'h0000_0100, 0},  // smallest positive
        '{-1, 32'hffff_ffff, 1, 1, 32'h0000_0000, 1},
        '{2,  32'h0004_0000, 0, 0, 0, 0},
        '{-1, 32'h0002_0000, 0, 0, 0, 0},
        '{-1, 32'h0002_0000, 0, 0, 0, 0},
        '{-1, 32'h0005_0000, 1, 0, 0, 0},
        '{-1, 32'h0001_0000, 0, 0, 0, 0},               // second pivot fails
        '{-1, 32'h0001_0000, 0, 0, 0, 0},
        '{-1, 32'h0001_0000, 0, 0, 0, 0},
        '{-1, 32'h0001_0000, 1, 0, 0, 0},
        '{-1, 32'h0000_0001, 0, 0, 0, 0},               // off-diagonal saturates
        '{-1, 32'h7fff_ffff, 0, 0, 0, 0},
        '{-1, 32'h7fff_ffff, 0, 0, 0, 0},
        '{-1, 32'h7fff_ffff, 1, 0, 0, 0},
        '{-1, 32'h0001_0000, 0, 0, 0, 0},
        '{-1, 32'h0000_0000, 0, 0, 0, 0},
        '{-1, 32'h0000_0000, 0, 0, 0, 0},
        '{-1, 32'h0001_0000, 0, 0, 0, 0},
        '{-1, 32'h0000_3039, 0, 0, 0, 0},               // surplus element
        '{-1, 32'h8000_0000, 1, 0, 0, 0},               // last mark on a surplus element
        '{-1, 32'h0004_0000, 1, 0, 0, 0},               // early last mark
        '{-1, 32'h0001_0000, 0, 0, 0, 0},
        '{0,  32'h0000_d903, 1, 0, 0, 0}                // size drops mid-load, acts as 1
    };

    initial
    begin
        factor_entry_t typed_entry;
        int unsigned   n;
        int unsigned   kind;
        int unsigned   early_at;
        int            scale;
        longint        a [ORDER_MAX][ORDER_MAX];
        longint        row_sum;
        logic signed [31:0] el;
        bit            last;

        in_valid  = 1'b0;
        element   = '0;
        is_last   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        out_stall = 1'b0;
        stall_mode = 0;
        stall_tick = 0;
        errors = 0;
        beats_sent = 0;
        entries_seen = 0;
        factors_done = 0;
        pivot_fails = 0;
        idle_cycles = 0;
        loaded   = 0;
        size_reg = 4'd8;
        for (int k = 0; k < ORDER_MAX*ORDER_MAX; k++)
        begin
            elem_store[k]   = 0;
            elem_written[k] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (10)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[k])
        begin
            if (directed[k].size_wr >= 0)
                write_size(directed[k].size_wr[3:0]);
            send_element(directed[k].el, directed[k].last);
            if (directed[k].typed)
            begin
                void'(pending_entries.pop_back());
                typed_entry.value      = directed[k].want_value;
                typed_entry.row        = 3'd0;
                typed_entry.col        = 3'd0;
                typed_entry.last_entry = 1'b1;
                typed_entry.bad_pivot  = directed[k].want_flag;
                pending_entries.push_back(typed_entry);
            end
        end
        write_size(4'd15);

        while (beats_sent < 130)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                case ($urandom_range(0, 9))
                    0: write_size(4'd0);
                    1: write_size(4'd15);
                    2: write_size(4'd8);
                    default: write_size(4'($urandom_range(1, 4)));
                endcase
            end
            n = order_of(size_reg);
            kind = $urandom_range(0, 9);
            scale = $urandom_range(8, 24);
            // diagonally dominant symmetric matrix
            for (int c = 0; c < n; c++)
                for (int r = 0; r < c; r++)
                begin
                    a[r][c] = longint'($urandom_range(0, 2 << scale)) - (longint'(1) << scale);
                    a[c][r] = a[r][c];
                end
            for (int r = 0; r < n; r++)
            begin
                row_sum = 0;
                for (int c = 0; c < n; c++)
                    if (c != r)
                        row_sum += (a[r][c] < 0) ? -a[r][c] : a[r][c];
                a[r][r] = row_sum + $urandom_range(1, 8 << scale);
            end
            early_at = (kind == 8 && n > 1) ? $urandom_range(0, n*n - 2) : n*n;
            for (int k = 0; k < n*n; k++)
            begin
                el = (kind == 9) ? $urandom : a[k % n][k / n][31:0];
                last = (k == n*n - 1) && (kind != 7);
                if (k == early_at && upper_covered(n))
                    last = 1'b1;
                send_element(el, last);
                if (last)
                    break;
            end
            if (kind == 7)
            begin
                repeat ($urandom_range(0, 2))
                    send_element($urandom, 1'b0);
                send_element($urandom, 1'b1);
            end
            if (factors_done % 7 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (200)
            @(posedge clk);
        if (pending_entries.size() != 0)
        begin
            $display("%0t: %0d factor entries never arrived", $time, pending_entries.size());
            errors++;
        end
        $display("%0d elements in, %0d factors of order 1 to %0d, %0d with a failed pivot",
                 beats_sent, factors_done, ORDER_MAX, pivot_fails);
        $display("%0d factor entries compared, %0d mismatches", entries_seen, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
